// File: hw/rtl/assert_macros.svh
// assertion helper macros for the byte queue rtl
// included by files that carry concurrent checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked every clock, off during reset
`define ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication, off during reset
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// File: hw/rtl/cbq_pkg.sv
// shared types and constants for the compacting byte queue
// no dependencies
package cbq_pkg;
  localparam int BufBytes = 256;
  localparam int IdxW = $clog2(BufBytes);
  localparam int CntW = IdxW + 1;

  typedef enum logic [2:0] {
    ACT_PUSH = 3'd0, ACT_POP = 3'd1, ACT_READ = 3'd2, ACT_INSERT = 3'd3,
    ACT_SET = 3'd4, ACT_CLEAR = 3'd5, ACT_HDR = 3'd6, ACT_TAIL = 3'd7
  } action_t;

  // datapath operation selected by the controller
  typedef enum logic [3:0] {
    OP_NONE, OP_DECIDE, OP_CMP_START, OP_CMP_STEP, OP_MOVE_START, OP_MOVE_RD,
    OP_MOVE_WR, OP_ACCESS, OP_FINISH, OP_FAIL
  } op_t;

  typedef struct packed {
    op_t  op;
    logic load;
  } cmd_t;

  typedef struct packed {
    logic need_compact;
    logic need_move;
    logic fail;
    logic done_loop;
  } status_t;
endpackage

// File: hw/rtl/compacting_byte_queue_core.sv
// top level of the compacting byte queue
// depends on cbq_pkg, cbq_ctrl and cbq_datapath
//
// usage: one command per s_axis transaction, one result per m_axis
// transaction. s_axis_tdata bits: action[2:0], data_byte[10:3],
// position[18:11], amount[26:19]. m_axis_tdata bits: read_data[7:0],
// ok[8], now_empty[9], fill_count[18:10].
// header_reserve is written with cfg_we/cfg_wdata while idle; the user
// is bound to this, as the block itself does not enforce it. compaction,
// and the right shift of insert or header space, run a read-then-write
// shift loop over the byte store.
// one command is in flight at a time; a new one is accepted in the cycle
// after the result transaction completes.
// reset empties the queue and clears header_reserve; the store is not
// cleared. a stalled receiver holds the result stable.
module compacting_byte_queue_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // action, data_byte, position, amount
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,  // read_data, ok, now_empty, fill_count
  input  logic        cfg_we,
  input  logic [7:0]  cfg_wdata
);
  import cbq_pkg::*;

  cmd_t cmd;
  status_t status;
  logic [7:0] hdr;
  logic [7:0] rdata;
  logic ok, emp;
  logic [CntW-1:0] cnt;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) hdr <= '0;
    else if (cfg_we) hdr <= cfg_wdata;
  end

  cbq_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
    .in_action(s_axis_tdata[2:0]), .status(status), .cmd(cmd)
  );

  cbq_datapath u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .status(status),
    .in_action(s_axis_tdata[2:0]), .in_data(s_axis_tdata[10:3]),
    .in_pos(s_axis_tdata[18:11]), .in_amount(s_axis_tdata[26:19]),
    .hdr_reserve(hdr), .res_data(rdata), .res_ok(ok), .res_empty(emp),
    .res_count(cnt)
  );

  assign m_axis_tdata = {5'd0, 9'(cnt), emp, ok, rdata};
endmodule

// File: hw/rtl/cbq_datapath.sv
// datapath: store, indices, count, shift unit and result register
// depends on cbq_pkg
module cbq_datapath (
  input  logic                 clk,
  input  logic                 rst,
  input  cbq_pkg::cmd_t        cmd,
  output cbq_pkg::status_t     status,
  input  logic [2:0]           in_action,
  input  logic [7:0]           in_data,
  input  logic [7:0]           in_pos,
  input  logic [7:0]           in_amount,
  input  logic [7:0]           hdr_reserve,
  output logic [7:0]           res_data,
  output logic                 res_ok,
  output logic                 res_empty,
  output logic [cbq_pkg::CntW-1:0] res_count
);
  import cbq_pkg::*;

  logic [7:0] mem [BufBytes];
  logic [IdxW-1:0] head, tail;
  logic [CntW-1:0] count;
  logic empty;
  logic [2:0] act;
  logic [7:0] dat, pos, amt;
  // move loop: copies left bytes, one registered read and one write per byte
  logic [IdxW-1:0] src, dst;
  logic [CntW-1:0] left;
  logic [7:0] hold;
  logic [7:0] rd_q;

  logic [CntW:0] t_plus_amt, t_plus_1;
  logic [IdxW-1:0] first_ix, acc_ix;
  logic [CntW-1:0] cnt_plus_amt;

  assign t_plus_1 = {{(CntW-IdxW+1){1'b0}}, tail} + 1'b1;
  assign t_plus_amt = {{(CntW-IdxW+1){1'b0}}, tail} + {{(CntW+1-8){1'b0}}, amt};
  assign cnt_plus_amt = count + {{(CntW-8){1'b0}}, amt};
  assign first_ix = ({{(32-8){1'b0}}, hdr_reserve} < BufBytes) ? IdxW'(hdr_reserve) : '0;
  // pop always takes the head byte
  assign acc_ix = head + ((action_t'(act) == ACT_POP) ? '0 : IdxW'(pos));

  // status decoded from the latched item
  always_comb begin
    status = '0;
    status.done_loop = (left == '0);
    case (action_t'(act))
      ACT_PUSH: begin
        status.fail = (count == CntW'(BufBytes));
        status.need_compact = !empty && (t_plus_1 >= (CntW+1)'(BufBytes)) && head != '0;
      end
      ACT_POP, ACT_READ, ACT_SET: begin
        status.fail = empty || ({1'b0, pos} >= count);
        if (action_t'(act) == ACT_POP) status.fail = empty;
      end
      ACT_INSERT: begin
        status.fail = (count == CntW'(BufBytes)) || ({1'b0, pos} > count);
        status.need_compact = !empty && (t_plus_1 >= (CntW+1)'(BufBytes)) && head != '0;
        status.need_move = ({1'b0, pos} != count);
      end
      ACT_CLEAR: status.fail = 1'b0;
      ACT_HDR: begin
        status.fail = empty || ({1'b0, head} < {1'b0, amt} &&
                      t_plus_amt >= (CntW+1)'(BufBytes));
        status.need_move = ({1'b0, head} < {1'b0, amt});
      end
      ACT_TAIL: begin
        status.fail = cnt_plus_amt > CntW'(BufBytes);
        status.need_compact = !empty && amt != '0 && head != '0 &&
                              t_plus_amt >= (CntW+1)'(BufBytes);
      end
      default: status = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    rd_q <= mem[acc_ix];
    if (rst) begin
      head <= '0; tail <= '0; count <= '0; empty <= 1'b1;
      left <= '0;
    end else begin
      if (cmd.load) begin
        act <= in_action; dat <= in_data; pos <= in_pos; amt <= in_amount;
      end
      case (cmd.op)
        OP_CMP_START: begin
          src <= head; dst <= '0; left <= count;
        end
        OP_CMP_STEP: begin
          // forward copy of the byte read in the previous cycle
          mem[dst] <= hold;
          src <= src + 1'b1; dst <= dst + 1'b1; left <= left - 1'b1;
          if (left == CntW'(1)) begin
            tail <= tail - head; head <= '0;
          end
        end
        OP_MOVE_START: begin
          // right shift, top byte first
          if (action_t'(act) == ACT_INSERT) begin
            src <= tail; dst <= tail + 1'b1;
            left <= count - {1'b0, pos};
          end else begin
            src <= tail; dst <= IdxW'(t_plus_amt);
            left <= count;
          end
        end
        OP_MOVE_RD: hold <= mem[src];
        OP_MOVE_WR: begin
          mem[dst] <= hold;
          src <= src - 1'b1; dst <= dst - 1'b1; left <= left - 1'b1;
        end
        OP_FINISH: begin
          case (action_t'(act))
            ACT_PUSH, ACT_INSERT: begin
              if (empty) begin
                head <= first_ix; tail <= first_ix; mem[first_ix] <= dat;
                count <= CntW'(1); empty <= 1'b0;
              end else begin
                if (action_t'(act) == ACT_INSERT) mem[acc_ix] <= dat;
                else mem[tail + 1'b1] <= dat;
                tail <= tail + 1'b1; count <= count + 1'b1;
              end
            end
            ACT_POP: begin
              if (count == CntW'(1)) begin
                head <= '0; tail <= '0; count <= '0; empty <= 1'b1;
              end else begin
                head <= head + 1'b1; count <= count - 1'b1;
              end
            end
            ACT_SET: mem[acc_ix] <= dat;
            ACT_CLEAR: begin
              head <= '0; tail <= '0; count <= '0; empty <= 1'b1;
            end
            ACT_HDR: begin
              if ({1'b0, head} < {1'b0, amt}) tail <= IdxW'(t_plus_amt);
              else head <= head - IdxW'(amt);
              count <= cnt_plus_amt;
            end
            ACT_TAIL: begin
              if (amt != '0) begin
                if (empty) begin
                  head <= '0; tail <= IdxW'(amt - 1'b1);
                  empty <= 1'b0;
                end else begin
                  tail <= IdxW'(t_plus_amt);
                end
                count <= cnt_plus_amt;
              end
            end
            default: ;
          endcase
        end
        default: ;
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.op == OP_ACCESS) begin
      res_data <= rd_q; res_ok <= 1'b1;
    end else if (cmd.op == OP_FAIL) begin
      res_data <= '0; res_ok <= 1'b0;
    end else if (cmd.op == OP_DECIDE || cmd.op == OP_CMP_START) begin
      res_data <= '0; res_ok <= 1'b1;
    end
  end
  assign res_empty = empty;
  assign res_count = count;
endmodule

// File: hw/rtl/cbq_ctrl.sv
// controller state machine for the byte queue
// depends on cbq_pkg and assert_macros.svh
`include "assert_macros.svh"
module cbq_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  input  logic [2:0]       in_action,
  input  cbq_pkg::status_t status,
  output cbq_pkg::cmd_t    cmd
);
  import cbq_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_DECIDE, S_CMP_RD, S_CMP_STEP, S_MOVE_START, S_MOVE_RD, S_MOVE_WR,
    S_ADDR, S_ACCESS, S_FINISH, S_OUT
  } state_t;

  state_t state;
  logic [2:0] act;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd = '0;
    cmd.load = in_valid && in_ready;
    case (state)
      S_DECIDE: begin
        if (status.fail) cmd.op = OP_FAIL;
        else if (status.need_compact) cmd.op = OP_CMP_START;
        else cmd.op = OP_DECIDE;
      end
      S_CMP_RD: cmd.op = status.done_loop ? OP_NONE : OP_MOVE_RD;
      S_CMP_STEP: cmd.op = OP_CMP_STEP;
      S_MOVE_START: cmd.op = OP_MOVE_START;
      S_MOVE_RD: cmd.op = status.done_loop ? OP_NONE : OP_MOVE_RD;
      S_MOVE_WR: cmd.op = OP_MOVE_WR;
      S_ACCESS: cmd.op = OP_ACCESS;
      S_FINISH: cmd.op = OP_FINISH;
      default: cmd.op = OP_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE; out_valid <= 1'b0; act <= '0;
    end else begin
      case (state)
        S_IDLE: if (in_valid) begin act <= in_action; state <= S_DECIDE; end
        S_DECIDE: begin
          if (status.fail) begin state <= S_OUT; out_valid <= 1'b1; end
          else if (status.need_compact) state <= S_CMP_RD;
          else if (status.need_move) state <= S_MOVE_START;
          else if (action_t'(act) == ACT_POP || action_t'(act) == ACT_READ)
            state <= S_ADDR;
          else state <= S_FINISH;
        end
        S_CMP_RD: begin
          if (status.done_loop)
            state <= status.need_move ? S_MOVE_START : S_FINISH;
          else state <= S_CMP_STEP;
        end
        S_CMP_STEP: state <= S_CMP_RD;
        S_MOVE_START: state <= S_MOVE_RD;
        S_MOVE_RD: if (status.done_loop) state <= S_FINISH;
                   else state <= S_MOVE_WR;
        S_MOVE_WR: state <= S_MOVE_RD;
        S_ADDR: state <= S_ACCESS;
        S_ACCESS: state <= (action_t'(act) == ACT_POP) ? S_FINISH : S_OUT;
        S_FINISH: state <= S_OUT;
        S_OUT: begin
          out_valid <= 1'b1;
          if (out_valid && out_ready) begin out_valid <= 1'b0; state <= S_IDLE; end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `ASSERT_IMPL(a_valid_only_out, out_valid, state == S_OUT)
  `ASSERT_IMPL(a_ready_idle, in_ready, !out_valid)
  `ASSERT_NEXT(a_take_decide, in_valid && in_ready, state == S_DECIDE)
endmodule
